### hw/rtl/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int DataW = 16;
    localparam int RadW  = 30;
    localparam int RootW = 15;
    localparam int RemW  = 18;
    localparam int NumW  = 29;
    localparam int SqrtSteps = RootW;
    localparam int DivSteps  = NumW;
    localparam int Lanes = 3;

    localparam logic signed [18:0] Q_ONE = 19'sd16384;

    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_X = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef struct packed {
        logic signed [DataW-1:0] r00;
        logic signed [DataW-1:0] r10;
        logic signed [DataW-1:0] r20;
        logic signed [DataW-1:0] r01;
        logic signed [DataW-1:0] r11;
        logic signed [DataW-1:0] r21;
        logic signed [DataW-1:0] r02;
        logic signed [DataW-1:0] r12;
        logic signed [DataW-1:0] r22;
    } t_mat;

    typedef struct packed {
        logic signed [DataW-1:0] qw;
        logic signed [DataW-1:0] qx;
        logic signed [DataW-1:0] qy;
        logic signed [DataW-1:0] qz;
        logic                    degenerate;
    } t_quat;

    typedef struct packed {
        logic                         valid;
        logic [1:0]                   branch;
        logic [RadW-1:0]              rad;
        logic [RemW-1:0]              rem;
        logic [RootW-1:0]             root;
        logic [Lanes-1:0][NumW-1:0]   num;
        logic [Lanes-1:0]             neg;
        logic [Lanes-1:0]             zero;
        logic [Lanes-1:0][NumW-1:0]   quo;
        logic [Lanes-1:0][RootW-1:0]  drem;
    } t_pipe;

endpackage

### hw/rtl/rmq_if.sv
`timescale 1ns / 1ps
interface rmq_in_if import rmq_pkg::*; ();
    logic valid;
    logic ready;
    t_mat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rmq_out_if import rmq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_quat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rmq_sqrt_stage.sv
`timescale 1ns / 1ps
module rmq_sqrt_stage import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_p,
    output t_pipe o_p
);
    t_pipe           r_p;
    t_pipe           n_p;
    logic [RemW-1:0] sh;
    logic [RemW-1:0] trial;

    always_comb begin
        n_p   = i_p;
        sh    = {i_p.rem[RemW-3:0], i_p.rad[RadW-1:RadW-2]};
        trial = {1'b0, i_p.root, 2'b01};
        n_p.rad = {i_p.rad[RadW-3:0], 2'b00};
        if (sh >= trial) begin
            n_p.rem  = sh - trial;
            n_p.root = {i_p.root[RootW-2:0], 1'b1};
        end else begin
            n_p.rem  = sh;
            n_p.root = {i_p.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.valid <= 1'b0;
        end else if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

### hw/rtl/rmq_div_stage.sv
`timescale 1ns / 1ps
module rmq_div_stage import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_p,
    output t_pipe o_p
);
    t_pipe r_p;
    t_pipe n_p;
    logic [Lanes-1:0][RootW:0] sh;

    always_comb begin
        n_p = i_p;
        for (int k = 0; k < Lanes; k++) begin
            sh[k] = {i_p.drem[k], i_p.num[k][NumW-1]};
            n_p.num[k] = {i_p.num[k][NumW-2:0], 1'b0};
            if (sh[k] >= {1'b0, i_p.root}) begin
                n_p.drem[k] = RootW'(sh[k] - {1'b0, i_p.root});
                n_p.quo[k]  = {i_p.quo[k][NumW-2:0], 1'b1};
            end else begin
                n_p.drem[k] = sh[k][RootW-1:0];
                n_p.quo[k]  = {i_p.quo[k][NumW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.valid <= 1'b0;
        end else if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

### hw/rtl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
// The pipeline has one input stage, 15 square root stages, 29 divider stages and one
// output register; each square root and divider stage resolves one result bit.
// Throughput is one matrix per cycle; the whole pipeline holds while the output waits.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmq_in_if.sink    i_mat,
    rmq_out_if.source o_quat
);
    logic en;
    t_pipe r_front;
    t_pipe n_front;
    t_pipe sq [SqrtSteps+1];
    t_pipe dv [DivSteps+1];
    t_quat r_out;
    t_quat n_out;
    logic  r_out_valid;
    logic signed [18:0] tr;
    logic signed [18:0] a;
    logic [1:0] br;
    logic signed [16:0] d [Lanes];
    logic signed [16:0] dm;
    logic signed [DataW-1:0] res [Lanes];
    logic [NumW-1:0] q;

    assign en = !r_out_valid || o_quat.ready;
    assign i_mat.ready = en;

    always_comb begin
        tr = 19'(i_mat.data.r00) + 19'(i_mat.data.r11) + 19'(i_mat.data.r22);
        if (tr > 19'sd0) begin
            br = BR_W;
            a  = Q_ONE + tr;
            d[0] = 17'(i_mat.data.r21) - 17'(i_mat.data.r12);
            d[1] = 17'(i_mat.data.r02) - 17'(i_mat.data.r20);
            d[2] = 17'(i_mat.data.r10) - 17'(i_mat.data.r01);
        end else if (i_mat.data.r00 > i_mat.data.r11 && i_mat.data.r00 > i_mat.data.r22) begin
            br = BR_X;
            a  = Q_ONE + 19'(i_mat.data.r00) - 19'(i_mat.data.r11) - 19'(i_mat.data.r22);
            d[0] = 17'(i_mat.data.r01) + 17'(i_mat.data.r10);
            d[1] = 17'(i_mat.data.r02) + 17'(i_mat.data.r20);
            d[2] = 17'(i_mat.data.r21) - 17'(i_mat.data.r12);
        end else if (i_mat.data.r11 > i_mat.data.r22) begin
            br = BR_Y;
            a  = Q_ONE - 19'(i_mat.data.r00) + 19'(i_mat.data.r11) - 19'(i_mat.data.r22);
            d[0] = 17'(i_mat.data.r01) + 17'(i_mat.data.r10);
            d[1] = 17'(i_mat.data.r12) + 17'(i_mat.data.r21);
            d[2] = 17'(i_mat.data.r02) - 17'(i_mat.data.r20);
        end else begin
            br = BR_Z;
            a  = Q_ONE - 19'(i_mat.data.r00) - 19'(i_mat.data.r11) + 19'(i_mat.data.r22);
            d[0] = 17'(i_mat.data.r02) + 17'(i_mat.data.r20);
            d[1] = 17'(i_mat.data.r12) + 17'(i_mat.data.r21);
            d[2] = 17'(i_mat.data.r10) - 17'(i_mat.data.r01);
        end
        n_front        = '0;
        n_front.valid  = i_mat.valid;
        n_front.branch = br;
        n_front.rad    = a[18] ? '0 : {a[17:0], 12'b0};
        for (int k = 0; k < Lanes; k++) begin
            dm = d[k][16] ? -d[k] : d[k];
            n_front.num[k]  = {dm[16:0], 12'b0};
            n_front.neg[k]  = d[k][16];
            n_front.zero[k] = (d[k] == 17'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (en) begin
            r_front <= n_front;
        end
    end

    assign sq[0] = r_front;

    for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
        rmq_sqrt_stage u_sqrt (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_p    (sq[g]),
            .o_p    (sq[g+1])
        );
    end

    assign dv[0] = sq[SqrtSteps];

    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        rmq_div_stage u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_p    (dv[g]),
            .o_p    (dv[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < Lanes; k++) begin
            q = dv[DivSteps].quo[k];
            if (dv[DivSteps].zero[k]) begin
                res[k] = '0;
            end else if (dv[DivSteps].neg[k]) begin
                res[k] = (q > NumW'(32768)) ? 16'sh8000 : -$signed(q[DataW-1:0]);
            end else begin
                res[k] = (q > NumW'(32767)) ? 16'sh7fff : $signed(q[DataW-1:0]);
            end
        end
        n_out.degenerate = (dv[DivSteps].root == '0);
        case (dv[DivSteps].branch)
            BR_W: begin
                n_out.qw = $signed({1'b0, dv[DivSteps].root});
                n_out.qx = res[0];
                n_out.qy = res[1];
                n_out.qz = res[2];
            end
            BR_X: begin
                n_out.qx = $signed({1'b0, dv[DivSteps].root});
                n_out.qy = res[0];
                n_out.qz = res[1];
                n_out.qw = res[2];
            end
            BR_Y: begin
                n_out.qy = $signed({1'b0, dv[DivSteps].root});
                n_out.qx = res[0];
                n_out.qz = res[1];
                n_out.qw = res[2];
            end
            default: begin
                n_out.qz = $signed({1'b0, dv[DivSteps].root});
                n_out.qx = res[0];
                n_out.qy = res[1];
                n_out.qw = res[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv[DivSteps].valid;
            r_out       <= n_out;
        end
    end

    assign o_quat.valid = r_out_valid;
    assign o_quat.data  = r_out;

`ifndef SYNTHESIS
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mat.ready == (!o_quat.valid || o_quat.ready))
        else $error("input ready does not follow output stall");
    a_degen_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid && o_quat.data.degenerate |->
        (o_quat.data.qw == 16'sd0 || o_quat.data.qx == 16'sd0 ||
         o_quat.data.qy == 16'sd0 || o_quat.data.qz == 16'sd0))
        else $error("degenerate result without a zero pivot");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_quat.valid)
        else $error("output valid right after reset");
`endif
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rmq_pkg::*;

    localparam int LATENCY    = 46;
    localparam int WATCH_MAX  = 5000;
    localparam int HOLD_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;

    rmq_in_if  mat_if ();
    rmq_out_if quat_if ();

    rotation_matrix_to_quaternion_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_if.sink),
        .o_quat  (quat_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_mat  pending_mats[$];
    t_quat expected_quats[$];
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_left;
    int    errors;
    int    accepted;
    int    returned;
    int    quiet_cycles;
    int    degenerate_seen;
    logic  stim_done;

    function automatic logic signed [15:0] div_quarter(int d, int c);
        longint q;
        if (c == 0) begin
            if (d > 0) return 16'sd32767;
            if (d < 0) return -16'sd32768;
            return 16'sd0;
        end
        q = (longint'(d) * 4096) / longint'(c);
        if (q > 32767) return 16'sd32767;
        if (q < -32768) return -16'sd32768;
        return q[15:0];
    endfunction

    function automatic int half_root(int a);
        longint n;
        longint r;
        if (a < 0) a = 0;
        n = longint'(a) * 4096;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        return int'(r);
    endfunction

    function automatic t_quat quat_of(t_mat m);
        t_quat q;
        int r00, r10, r20, r01, r11, r21, r02, r12, r22, tr, c;
        r00 = int'(m.r00); r10 = int'(m.r10); r20 = int'(m.r20);
        r01 = int'(m.r01); r11 = int'(m.r11); r21 = int'(m.r21);
        r02 = int'(m.r02); r12 = int'(m.r12); r22 = int'(m.r22);
        tr = r00 + r11 + r22;
        if (tr > 0) begin
            c = half_root(16384 + tr);
            q.qw = c[15:0];
            q.qx = div_quarter(r21 - r12, c);
            q.qy = div_quarter(r02 - r20, c);
            q.qz = div_quarter(r10 - r01, c);
        end else if (r00 > r11 && r00 > r22) begin
            c = half_root(16384 + r00 - r11 - r22);
            q.qx = c[15:0];
            q.qy = div_quarter(r01 + r10, c);
            q.qz = div_quarter(r02 + r20, c);
            q.qw = div_quarter(r21 - r12, c);
        end else if (r11 > r22) begin
            c = half_root(16384 - r00 + r11 - r22);
            q.qy = c[15:0];
            q.qx = div_quarter(r01 + r10, c);
            q.qz = div_quarter(r12 + r21, c);
            q.qw = div_quarter(r02 - r20, c);
        end else begin
            c = half_root(16384 - r00 - r11 + r22);
            q.qz = c[15:0];
            q.qx = div_quarter(r02 + r20, c);
            q.qy = div_quarter(r12 + r21, c);
            q.qw = div_quarter(r10 - r01, c);
        end
        q.degenerate = (c == 0);
        return q;
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 32768)) - 16384);
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly near-rotations: a signed permutation of the unit diagonal with small noise.
    function automatic t_mat rand_mat();
        t_mat m;
        logic [15:0] e[9];
        int p, k;
        if ($urandom_range(0, 3) == 0) begin
            foreach (e[i]) e[i] = rand_elem();
        end else begin
            p = $urandom_range(0, 5);
            foreach (e[i]) e[i] = 16'($signed($urandom_range(0, 8192)) - 4096);
            for (k = 0; k < 3; k++) begin
                int col;
                col = (k + p) % 3;
                if (p >= 3) col = (p - k) % 3;
                e[k * 3 + col] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                e[k * 3 + col] = e[k * 3 + col] + 16'($signed($urandom_range(0, 200)) - 100);
            end
        end
        m.r00 = e[0]; m.r01 = e[1]; m.r02 = e[2];
        m.r10 = e[3]; m.r11 = e[4]; m.r12 = e[5];
        m.r20 = e[6]; m.r21 = e[7]; m.r22 = e[8];
        return m;
    endfunction

    function automatic t_mat mk(int d0, int d1, int d2, int off);
        t_mat m;
        m.r00 = 16'(d0); m.r11 = 16'(d1); m.r22 = 16'(d2);
        m.r10 = 16'(off); m.r20 = 16'(-off); m.r01 = 16'(off + 7);
        m.r21 = 16'(off - 3); m.r02 = 16'(-off + 5); m.r12 = 16'(off + 1);
        return m;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_if.valid <= 1'b0;
        end else if (!mat_if.valid || mat_if.ready) begin
            if (mat_if.valid) pending_mats.pop_front();
            if (pending_mats.size() > 0 &&
                $urandom_range(1, 100) > send_idle_pct) begin
                mat_if.valid <= 1'b1;
                mat_if.data  <= pending_mats[0];
            end else begin
                mat_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            quat_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            quat_if.ready <= 1'b0;
        end else begin
            quat_if.ready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_quat want;
        t_quat got;
        if (i_rst_n) begin
            if (mat_if.valid && mat_if.ready) begin
                expected_quats.push_back(quat_of(mat_if.data));
                accepted++;
            end
            if (quat_if.valid && quat_if.ready) begin
                got = quat_if.data;
                returned++;
                if (got.degenerate) degenerate_seen++;
                if (expected_quats.size() == 0) begin
                    $error("quaternion with no matrix pending");
                    errors++;
                end else begin
                    want = expected_quats.pop_front();
                    if (got.qw !== want.qw) begin
                        $error("qw exp %0d got %0d", want.qw, got.qw); errors++;
                    end
                    if (got.qx !== want.qx) begin
                        $error("qx exp %0d got %0d", want.qx, got.qx); errors++;
                    end
                    if (got.qy !== want.qy) begin
                        $error("qy exp %0d got %0d", want.qy, got.qy); errors++;
                    end
                    if (got.qz !== want.qz) begin
                        $error("qz exp %0d got %0d", want.qz, got.qz); errors++;
                    end
                    if (got.degenerate !== want.degenerate) begin
                        $error("degenerate exp %0d got %0d", want.degenerate, got.degenerate);
                        errors++;
                    end
                end
            end
            if ((mat_if.valid && mat_if.ready) || (quat_if.valid && quat_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCH_MAX) begin
                $display("timeout with %0d quaternions outstanding", expected_quats.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        t_mat m;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        mat_if.valid = 1'b0;
        mat_if.data = '0;
        quat_if.ready = 1'b0;
        errors = 0; accepted = 0; returned = 0; quiet_cycles = 0; degenerate_seen = 0;
        stim_done = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 81;

        // Directed cases cover each branch, ties, zero pivots and the extremes.
        pending_mats.push_back(mk(16384, 16384, 16384, 0));
        pending_mats.push_back(mk(16384, -16384, -16384, 100));
        pending_mats.push_back(mk(-16384, 16384, -16384, -100));
        pending_mats.push_back(mk(-16384, -16384, 16384, 2000));
        pending_mats.push_back(mk(0, 0, 0, 50));
        pending_mats.push_back(mk(-5000, -5000, -5000, 300));
        pending_mats.push_back(mk(-100, -100, -8000, 9));
        pending_mats.push_back(mk(-8000, -100, -100, 9));
        pending_mats.push_back(mk(-32768, -32768, -32768, 0));
        pending_mats.push_back(mk(32767, 32767, 32767, 32000));
        pending_mats.push_back(mk(-32768, 32767, -32768, -32000));
        pending_mats.push_back(mk(-16384, -16384, -16384, 0));
        pending_mats.push_back(mk(-16384, -16384, -16384, 1234));
        pending_mats.push_back(mk(-16384, -16384, -16384, -1234));
        pending_mats.push_back(mk(32767, -32768, -32768, 0));
        pending_mats.push_back(mk(1, 0, 0, 32767));
        pending_mats.push_back(mk(-8192, 4096, 4096, 0));
        m = '1;
        pending_mats.push_back(m);
        m = {9{16'h8000}};
        pending_mats.push_back(m);
        m = {9{16'h7fff}};
        pending_mats.push_back(m);
        m = '0;
        pending_mats.push_back(m);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 220; i++) pending_mats.push_back(rand_mat());
        wait (pending_mats.size() <= 1 && !mat_if.valid);
        wait (expected_quats.size() == 0);

        send_idle_pct = 81;
        recv_idle_pct = 17;
        for (int i = 0; i < 200; i++) pending_mats.push_back(rand_mat());
        @(posedge i_clk);
        hold_left <= HOLD_CYCLES;
        send_idle_pct = 0;
        @(posedge i_clk);
        wait (hold_left == 0);
        send_idle_pct = 81;
        wait (pending_mats.size() == 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 220; i++) pending_mats.push_back(rand_mat());
        wait (pending_mats.size() == 0);
        wait (expected_quats.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d matrices, %0d quaternions, %0d degenerate",
                 accepted, returned, degenerate_seen);
        $display("phases: slow receiver, slow sender with long output stall, full rate");
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### rotation_matrix_to_quaternion_top.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_if.sv
hw/rtl/rmq_sqrt_stage.sv
hw/rtl/rmq_div_stage.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
tb/tb_top.sv
